// File: rtl/core/contiguous_chunk_counter_unit_assert.svh
// Assertion macros for the contiguous chunk counter.
// Included by the RTL modules that carry concurrent assertions; needs no package.
`ifndef CONTIGUOUS_CHUNK_COUNTER_UNIT_ASSERT_SVH
`define CONTIGUOUS_CHUNK_COUNTER_UNIT_ASSERT_SVH

// Property that holds at every clock edge outside reset
`define CCC_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent that holds in the cycle after the antecedent
`define CCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/ccc_pkg.sv
// Shared types and constants for the contiguous chunk counter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ccc_pkg;

    localparam int DIM_W      = 31;
    localparam int CNT_W      = 32;
    localparam int PROD_W     = CNT_W + DIM_W;
    localparam int MUL_STEPS  = DIM_W;
    localparam int DIV_STEPS  = CNT_W;
    localparam int STEP_CNT_W = 5;

    localparam logic [CNT_W-1:0] COUNT_SAT = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DIV2,
        ST_DONE
    } ccc_state_t;

endpackage

`default_nettype wire

// File: rtl/core/ccc_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// Depends on ccc_pkg for widths and step count.
`default_nettype none

module ccc_mul
    import ccc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  a,
    input  wire logic [DIM_W-1:0]  b,
    output logic                   busy,
    output logic [PROD_W-1:0]      prod
);

    logic [CNT_W-1:0]      a_reg;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [DIM_W-1:0]      lo_reg, lo_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [CNT_W:0]        sum;

    // Add the multiplicand under the current multiplier bit, then shift right
    always_comb
    begin
        sum       = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : '0);
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = STEP_CNT_W'(MUL_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next = sum[CNT_W:1];
            lo_next = {sum[0], lo_reg[DIM_W-1:1]};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - STEP_CNT_W'(1);
            end
        end
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Operand and partial product shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
        end
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

`default_nettype wire

// File: rtl/core/ccc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, MSB first.
// Depends on ccc_pkg for widths and step count.
`default_nettype none

module ccc_div
    import ccc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [CNT_W-1:0]  num,
    input  wire logic [DIM_W-1:0]  den,
    output logic                   busy,
    output logic [CNT_W-1:0]       quo
);

    logic [DIM_W-1:0]      den_reg;
    logic [DIM_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      quo_reg, quo_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      trial;
    logic [CNT_W-1:0]      diff;
    logic                  fits;

    // Bring down the next dividend bit and subtract where the divisor fits
    always_comb
    begin
        trial     = {rem_reg, quo_reg[CNT_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            cnt_next  = STEP_CNT_W'(DIV_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
            quo_next = {quo_reg[CNT_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - STEP_CNT_W'(1);
            end
        end
    end

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // Divisor, remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/core/contiguous_chunk_counter_unit.sv
// Contiguous chunk counter top level: sequencer, state and result register.
// Depends on ccc_pkg, ccc_mul, ccc_div and contiguous_chunk_counter_unit_assert.svh.
//
// Takes array dimension sizes one item at a time, fastest varying first, and on
// the item flagged last_dim delivers how many contiguous chunks of at most
// max_pixels pixels cover the array. One item is worked on at a time; a result
// waiting in the output register does not block the next item. Timing comes
// from two bit-serial units: a 31-step shift-add multiplier and a 32-step
// restoring divider. An item before the break runs the multiply alongside the
// limit/stride divide; the dimension that breaks the stride then runs a second
// divide for its chunk count; an item after the break runs one multiply. With
// a zero limit or a saturated count an item uses neither unit. A last item
// whose result finds the output register still full waits until it drains.
// max_pixels is taken only while no item is in progress, and an item offered
// together with a limit write is held off until the write has landed.
`default_nettype none

`include "contiguous_chunk_counter_unit_assert.svh"

module contiguous_chunk_counter_unit
    import ccc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [DIM_W-1:0]  max_pixels,
    // dimension item channel
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [DIM_W-1:0]  dim_size,
    input  wire logic              last_dim,
    // result item channel
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [CNT_W-1:0]       chunk_count,
    output logic                   invalid_limit,
    output logic                   count_overflow
);

    ccc_state_t state_reg, state_next;

    logic [DIM_W-1:0]  max_reg;
    logic [DIM_W-1:0]  dim_reg;
    logic              last_reg;
    logic [DIM_W-1:0]  stride_reg, stride_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              broken_reg, broken_next;
    logic              ovf_reg, ovf_next;

    logic              out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]  chunk_count_reg;
    logic              invalid_reg;
    logic              overflow_reg;

    logic              in_accept;
    logic              out_free;
    logic              out_load;
    logic              limit_zero;
    logic              units_done;
    logic              prod_over;
    logic [DIM_W-1:0]  inc;

    logic              mul_start;
    logic [CNT_W-1:0]  mul_a;
    logic              mul_busy;
    logic [PROD_W-1:0] mul_prod;

    logic              div_start;
    logic [CNT_W-1:0]  div_num;
    logic [DIM_W-1:0]  div_den;
    logic              div_busy;
    logic [CNT_W-1:0]  div_quo;

    // Handshake terms; hold items back while a limit write is offered
    assign in_stall   = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready  = (state_reg == ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign limit_zero = (max_reg == '0);
    assign units_done = !mul_busy && !div_busy;

    // Stride product beyond the limit; chunk step is limit/stride, at least one
    assign prod_over = (mul_prod[PROD_W-1:DIM_W] != '0) || (mul_prod[DIM_W-1:0] > max_reg);
    assign inc       = ((stride_reg == '0) || (div_quo == '0)) ? DIM_W'(1) : div_quo[DIM_W-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (limit_zero || (broken_reg && ovf_reg))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (units_done)
                begin
                    state_next = (!broken_reg && prod_over) ? ST_DIV2 : ST_DONE;
                end
            end
            ST_DIV2:
            begin
                if (!div_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!last_reg || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Unit starts, operands and state updates
    always_comb
    begin
        mul_start   = 1'b0;
        mul_a       = broken_reg ? count_reg : {1'b0, stride_reg};
        div_start   = 1'b0;
        div_num     = {1'b0, max_reg};
        div_den     = stride_reg;
        stride_next = stride_reg;
        count_next  = count_reg;
        broken_next = broken_reg;
        ovf_next    = ovf_reg;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && !limit_zero)
                begin
                    mul_start = !(broken_reg && ovf_reg);
                    div_start = !broken_reg;
                end
            end
            ST_RUN:
            begin
                if (units_done)
                begin
                    if (!broken_reg)
                    begin
                        if (prod_over)
                        begin
                            div_start = 1'b1;
                            div_num   = {1'b0, dim_reg} - CNT_W'(1);
                            div_den   = inc;
                        end
                        else
                        begin
                            stride_next = mul_prod[DIM_W-1:0];
                        end
                    end
                    else if (mul_prod[PROD_W-1:CNT_W] != '0)
                    begin
                        count_next = COUNT_SAT;
                        ovf_next   = 1'b1;
                    end
                    else
                    begin
                        count_next = mul_prod[CNT_W-1:0];
                    end
                end
            end
            ST_DIV2:
            begin
                if (!div_busy)
                begin
                    count_next  = div_quo + CNT_W'(1);
                    broken_next = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (last_reg && out_free)
                begin
                    out_load    = 1'b1;
                    stride_next = DIM_W'(1);
                    count_next  = CNT_W'(1);
                    broken_next = 1'b0;
                    ovf_next    = 1'b0;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // Result register: load on a finished array, drop when taken
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and array state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            max_reg       <= DIM_W'(1);
            stride_reg    <= DIM_W'(1);
            count_reg     <= CNT_W'(1);
            broken_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stride_reg    <= stride_next;
            count_reg     <= count_next;
            broken_reg    <= broken_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                max_reg <= max_pixels;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dim_reg  <= dim_size;
            last_reg <= last_dim;
        end
        if (out_load)
        begin
            chunk_count_reg <= limit_zero ? '0 : count_reg;
            invalid_reg     <= limit_zero;
            overflow_reg    <= !limit_zero && ovf_reg;
        end
    end

    ccc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (dim_size),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

    ccc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign out_valid      = out_valid_reg;
    assign chunk_count    = chunk_count_reg;
    assign invalid_limit  = invalid_reg;
    assign count_overflow = overflow_reg;

    `CCC_ASSERT_ALWAYS(a_count_one_before_break, clk, rst_n,
        broken_reg || (count_reg == CNT_W'(1)), "count moved before any break")
    `CCC_ASSERT_ALWAYS(a_saturated_count, clk, rst_n,
        !ovf_reg || (count_reg == COUNT_SAT), "overflow flag without saturated count")
    `CCC_ASSERT_ALWAYS(a_div2_only_unbroken, clk, rst_n,
        (state_reg != ST_DIV2) || !broken_reg, "chunk divide after the break")
    `CCC_ASSERT_NEXT(a_clear_after_result, clk, rst_n, out_load,
        out_valid_reg && !broken_reg && (stride_reg == DIM_W'(1)), "state not cleared")

endmodule

`default_nettype wire

// File: sim/ccc_chunk_checker.sv
// Checker for the contiguous chunk counter: follows the limit writes and dimension items,
// predicts each chunk count result and compares it with what the block delivers.
// Depends on ccc_pkg for widths and the saturation value.
module ccc_chunk_checker
    import ccc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [DIM_W-1:0]  max_pixels,
    input  logic              in_valid,
    input  logic              in_stall,
    input  logic [DIM_W-1:0]  dim_size,
    input  logic              last_dim,
    input  logic              out_valid,
    input  logic              out_stall,
    input  logic [CNT_W-1:0]  chunk_count,
    input  logic              invalid_limit,
    input  logic              count_overflow,
    output int                mismatches,
    output int                results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CNT_W-1:0] chunk_count;
        logic             invalid_limit;
        logic             count_overflow;
    } chunk_result_t;

    chunk_result_t    expected_counts[$];
    logic [DIM_W-1:0] limit_copy;
    logic [DIM_W-1:0] span_stride;
    logic             dims_broken;
    logic [CNT_W-1:0] chunk_total;
    logic             total_saturated;

    // Return the array state to its starting point
    function automatic void clear_array();
        span_stride     = 1;
        dims_broken     = 1'b0;
        chunk_total     = 1;
        total_saturated = 1'b0;
    endfunction

    // Fold one dimension into the array state; queue a result on the last one
    function automatic void fold_dimension(input logic [DIM_W-1:0] dim, input logic last);
        logic [63:0]      span;
        logic [63:0]      product;
        logic [CNT_W-1:0] per_chunk;
        logic [CNT_W-1:0] dim_minus_one;
        chunk_result_t    res;
        if (limit_copy != 0) begin
            if (!dims_broken) begin
                span = 64'(span_stride) * 64'(dim);
                if (span > 64'(limit_copy)) begin
                    per_chunk = (span_stride != 0) ? CNT_W'(limit_copy) / CNT_W'(span_stride)
                                                   : CNT_W'(1);
                    if (per_chunk == 0)
                        per_chunk = 1;
                    dim_minus_one = CNT_W'(dim) - CNT_W'(1);
                    chunk_total   = dim_minus_one / per_chunk + CNT_W'(1);
                    dims_broken   = 1'b1;
                end
                else begin
                    span_stride = span[DIM_W-1:0];
                end
            end
            else if (!total_saturated) begin
                product = 64'(chunk_total) * 64'(dim);
                if (product > 64'(COUNT_SAT)) begin
                    chunk_total     = COUNT_SAT;
                    total_saturated = 1'b1;
                end
                else begin
                    chunk_total = product[CNT_W-1:0];
                end
            end
        end
        if (last) begin
            if (limit_copy == 0) begin
                res.chunk_count    = '0;
                res.invalid_limit  = 1'b1;
                res.count_overflow = 1'b0;
            end
            else begin
                res.chunk_count    = chunk_total;
                res.invalid_limit  = 1'b0;
                res.count_overflow = total_saturated;
            end
            expected_counts.push_back(res);
            clear_array();
        end
    endfunction

    // Follow the channels at each rising edge: results first, then limit, then items
    always @(posedge clk or negedge rst_n) begin
        chunk_result_t want;
        if (!rst_n) begin
            expected_counts.delete();
            limit_copy      = 1;
            clear_array();
            mismatches      = 0;
            results_pending = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_counts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result count %0d invalid %0b overflow %0b",
                                 $realtime, chunk_count, invalid_limit, count_overflow);
                end
                else begin
                    want = expected_counts.pop_front();
                    if (chunk_count !== want.chunk_count
                        || invalid_limit !== want.invalid_limit
                        || count_overflow !== want.count_overflow) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: chunk result differs: expected count %0d ",
                                      "invalid %0b overflow %0b, got count %0d ",
                                      "invalid %0b overflow %0b"},
                                     $realtime, want.chunk_count, want.invalid_limit,
                                     want.count_overflow, chunk_count, invalid_limit,
                                     count_overflow);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                limit_copy = max_pixels;
            if (in_valid && !in_stall)
                fold_dimension(dim_size, last_dim);
            results_pending = expected_counts.size();
        end
    end

endmodule

// File: sim/contiguous_chunk_counter_unit_tb.sv
// Testbench top for the contiguous chunk counter: clock, reset, limit writes,
// dimension stimulus and output back-pressure; the verdict uses ccc_chunk_checker.
// Depends on ccc_pkg, contiguous_chunk_counter_unit and ccc_chunk_checker.
module contiguous_chunk_counter_unit_tb
    import ccc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_DIMS   = 950;
    localparam int QUIET_FROM   = 800;
    localparam int PRESSURE_AT  = 400;
    localparam int HOLD_CYCLES  = 500;
    localparam int SETTLE       = 100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam logic [DIM_W-1:0] DIM_MAX = {DIM_W{1'b1}};

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [DIM_W-1:0] max_pixels = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [DIM_W-1:0] dim_size = '0;
    logic             last_dim = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [CNT_W-1:0] chunk_count;
    logic             invalid_limit;
    logic             count_overflow;

    int               mismatch_count;
    int               results_pending;
    int               cycle_count = 0;
    int               dims_sent = 0;
    logic             in_taken = 1'b0;
    logic             cfg_taken = 1'b0;
    logic [DIM_W-1:0] cur_limit = 1;
    bit               quiet = 1'b0;
    bit               hold_req = 1'b0;
    bit               hold_done = 1'b0;

    contiguous_chunk_counter_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .max_pixels    (max_pixels),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .dim_size      (dim_size),
        .last_dim      (last_dim),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .chunk_count   (chunk_count),
        .invalid_limit (invalid_limit),
        .count_overflow(count_overflow)
    );

    ccc_chunk_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .max_pixels     (max_pixels),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .dim_size       (dim_size),
        .last_dim       (last_dim),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .chunk_count    (chunk_count),
        .invalid_limit  (invalid_limit),
        .count_overflow (count_overflow),
        .mismatches     (mismatch_count),
        .results_pending(results_pending)
    );

    always #4 clk = ~clk;

    // Register handshakes at the rising edge so the falling-edge driver reads them race-free
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        in_taken    <= in_valid && !in_stall;
        cfg_taken   <= cfg_valid && cfg_ready;
    end

    // Abort a run that hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stall the result channel in random bursts, with one long hold-off on request
    initial begin
        int burst;
        wait (rst_n);
        forever begin
            @(negedge clk);
            if (hold_req && !hold_done) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst     = $urandom_range(1, 7);
                out_stall = 1'b1;
                repeat (burst) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // Offer one dimension item, with an occasional idle burst ahead of it
    task automatic send_dim(input logic [DIM_W-1:0] dim, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap      = $urandom_range(1, 7);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        dim_size = dim;
        last_dim = last;
        do @(negedge clk); while (!in_taken);
        dims_sent++;
    endtask

    // Drop valid, drain all results, then let any item still in work finish
    task automatic wait_idle();
        in_valid = 1'b0;
        while (results_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write the pixel limit; call only while the block is idle
    task automatic set_limit(input logic [DIM_W-1:0] value);
        cfg_valid  = 1'b1;
        max_pixels = value;
        do @(negedge clk); while (!cfg_taken);
        cfg_valid = 1'b0;
        cur_limit = value;
    endtask

    function automatic logic [DIM_W-1:0] pick_limit();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 10)
            return '0;
        else if (sel < 20)
            return 1;
        else if (sel < 30)
            return DIM_MAX;
        else if (sel < 60)
            return DIM_W'($urandom_range(2, 64));
        else if (sel < 80)
            return DIM_W'($urandom_range(65, 100000));
        else
            return DIM_W'($urandom);
    endfunction

    // Mix small sizes, sizes near the limit, full-width sizes and the edges
    function automatic logic [DIM_W-1:0] pick_dim();
        int     sel;
        longint lo;
        longint hi;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return DIM_W'($urandom_range(1, 8));
        else if (sel < 45)
            return DIM_W'($urandom_range(1, 64));
        else if (sel < 65 && cur_limit != 0) begin
            lo = longint'(cur_limit) / 4 + 1;
            hi = longint'(cur_limit) * 2;
            if (hi > longint'(DIM_MAX))
                hi = longint'(DIM_MAX);
            return DIM_W'($urandom_range(int'(unsigned'(32'(lo))), int'(unsigned'(32'(hi)))));
        end
        else if (sel < 85)
            return DIM_W'($urandom);
        else if (sel < 90)
            return '0;
        else if (sel < 95)
            return DIM_MAX;
        else
            return 1;
    endfunction

    initial begin
        int arrays;
        int ndim;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: no break, a break, later dimensions, zero sizes, saturation
        set_limit(10);
        send_dim(2, 1'b0);
        send_dim(3, 1'b1);
        send_dim(4, 1'b0);
        send_dim(5, 1'b1);
        send_dim(2, 1'b0);
        send_dim(7, 1'b0);
        send_dim(3, 1'b0);
        send_dim(5, 1'b1);
        send_dim(0, 1'b0);
        send_dim(1000, 1'b0);
        send_dim(5, 1'b1);
        send_dim(20, 1'b0);
        send_dim(0, 1'b1);
        send_dim(DIM_MAX, 1'b0);
        send_dim(DIM_MAX, 1'b0);
        send_dim(DIM_MAX, 1'b1);
        wait_idle();

        // Directed: zero limit, including an item held over into a valid limit
        set_limit(0);
        send_dim(5, 1'b0);
        send_dim(7, 1'b1);
        send_dim(3, 1'b0);
        wait_idle();
        set_limit(8);
        send_dim(4, 1'b1);
        wait_idle();

        // Directed: limit lowered mid-array below the stride
        set_limit(4);
        send_dim(2, 1'b0);
        wait_idle();
        set_limit(1);
        send_dim(3, 1'b1);
        send_dim(DIM_MAX, 1'b1);
        wait_idle();
        set_limit(DIM_MAX);
        send_dim(65536, 1'b0);
        send_dim(65536, 1'b1);
        send_dim(1, 1'b1);
        wait_idle();

        // Random phases of well-formed arrays, some left open across a limit change
        while (dims_sent < TOTAL_DIMS) begin
            quiet = (dims_sent >= QUIET_FROM);
            if (!hold_req && dims_sent >= PRESSURE_AT) begin
                set_limit(1000);
                hold_req = 1'b1;
                repeat (12) send_dim(DIM_W'($urandom_range(1, 5000)), 1'b1);
                wait_idle();
            end
            if ($urandom_range(0, 3) != 0)
                set_limit(pick_limit());
            arrays = $urandom_range(2, 8);
            repeat (arrays) begin
                ndim = $urandom_range(1, 5);
                for (int d = 0; d < ndim; d++)
                    send_dim(pick_dim(), d == ndim - 1);
            end
            if ($urandom_range(0, 4) == 0)
                send_dim(pick_dim(), 1'b0);
            wait_idle();
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ccc_pkg.sv
rtl/core/ccc_mul.sv
rtl/core/ccc_div.sv
rtl/core/contiguous_chunk_counter_unit.sv
sim/ccc_chunk_checker.sv
sim/contiguous_chunk_counter_unit_tb.sv
